>>> hdl/rpn_pkg.sv
// rpn_pkg: shared types, constants and codes for the RPN stack evaluator.
// No dependencies; used by rpn_alu and rpn_stack_evaluator.

package rpn_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 128;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int PTR_W       = $clog2(STACK_DEPTH + 1);

  localparam int DATA_W    = 32;
  localparam int DIV_STEPS = DATA_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Character codes
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_ADD = 8'h2B;
  localparam logic [7:0] CH_SUB = 8'h2D;
  localparam logic [7:0] CH_MUL = 8'h2A;
  localparam logic [7:0] CH_DIV = 8'h2F;
  localparam logic [7:0] CH_EQ  = 8'h3D;

  // Sticky status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OVERFLW = 2'd1;
  localparam logic [1:0] ST_DIVZERO = 2'd2;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic divzero;
  } alu_rsp_t;

  typedef enum logic [1:0] {
    A_IDLE,
    A_DIV,
    A_FIX,
    A_DONE
  } alu_state_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_A,
    S_EXEC,
    S_WAIT,
    S_EQ
  } seq_state_t;

endpackage

>>> hdl/rpn_ram.sv
// rpn_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.

module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/rpn_alu.sv
// rpn_alu: shared arithmetic unit - add, subtract, multiply in one step,
// signed divide by a radix-2 restoring loop. Depends on rpn_pkg.

module rpn_alu (
  input  logic                     clk,
  input  logic                     rst,
  input  rpn_pkg::alu_req_t        req,
  input  logic [rpn_pkg::DATA_W-1:0] a,
  input  logic [rpn_pkg::DATA_W-1:0] b,
  output rpn_pkg::alu_rsp_t        rsp,
  output logic [rpn_pkg::DATA_W-1:0] result
);

  rpn_pkg::alu_state_t state, state_next;

  logic [rpn_pkg::CNT_W-1:0]  count;
  logic                       neg;
  logic                       divzero;
  logic [rpn_pkg::DATA_W-1:0] divisor;
  logic [rpn_pkg::DATA_W-1:0] quo;
  logic [rpn_pkg::DATA_W-1:0] rem;
  logic [rpn_pkg::DATA_W:0]   rem_sh;
  logic [rpn_pkg::DATA_W:0]   trial;
  logic                       trial_ok;

  // one restoring step
  assign rem_sh   = {rem, quo[rpn_pkg::DATA_W-1]};
  assign trial    = rem_sh - {1'b0, divisor};
  assign trial_ok = !trial[rpn_pkg::DATA_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rpn_pkg::A_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      rpn_pkg::A_IDLE: begin
        if (req.start) begin
          divzero <= 1'b0;
          unique case (req.op)
            rpn_pkg::ALU_ADD: result <= a + b;
            rpn_pkg::ALU_SUB: result <= a - b;
            rpn_pkg::ALU_MUL: result <= a * b;
            rpn_pkg::ALU_DIV: begin
              divzero <= (b == '0);
              result  <= '0;
              neg     <= a[rpn_pkg::DATA_W-1] ^ b[rpn_pkg::DATA_W-1];
              quo     <= a[rpn_pkg::DATA_W-1] ? (-a) : a;
              divisor <= b[rpn_pkg::DATA_W-1] ? (-b) : b;
              rem     <= '0;
              count   <= '0;
            end
          endcase
        end
      end
      rpn_pkg::A_DIV: begin
        rem   <= trial_ok ? trial[rpn_pkg::DATA_W-1:0] : rem_sh[rpn_pkg::DATA_W-1:0];
        quo   <= {quo[rpn_pkg::DATA_W-2:0], trial_ok};
        count <= count + 1'b1;
      end
      rpn_pkg::A_FIX: result <= neg ? (-quo) : quo;
      rpn_pkg::A_DONE: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rpn_pkg::A_IDLE: begin
        if (req.start) begin
          if (req.op == rpn_pkg::ALU_DIV && b != '0) begin
            state_next = rpn_pkg::A_DIV;
          end else begin
            state_next = rpn_pkg::A_DONE;
          end
        end
      end
      rpn_pkg::A_DIV: begin
        if (count == rpn_pkg::CNT_W'(rpn_pkg::DIV_STEPS - 1)) begin
          state_next = rpn_pkg::A_FIX;
        end
      end
      rpn_pkg::A_FIX:  state_next = rpn_pkg::A_DONE;
      rpn_pkg::A_DONE: state_next = rpn_pkg::A_IDLE;
    endcase
  end

  always_comb begin
    rsp.done    = (state == rpn_pkg::A_DONE);
    rsp.divzero = divzero;
  end

endmodule

>>> hdl/rpn_stack_evaluator.sv
// rpn_stack_evaluator: top level of the RPN calculator - sequencer, stack pointer,
// sticky status and result register. Depends on rpn_pkg, rpn_ram, rpn_alu.
//
//   Channel  Dir  Handshake            Payload
//   -------  ---  -------------------  -----------------------------------
//   in       in   in_valid / in_stall  ch     [7:0]  unsigned character
//   out      out  out_valid/out_stall  value  [31:0] signed, status [1:0]
//
// Each beat: a digit or ignored character is taken in the idle state; '=' waits
// only while an earlier result is still held on out; an operator does two stack
// reads, the start and the push, and '/' adds the 32-step radix-2 loop in rpn_alu
// and the sign fix, both skipped when the divisor is zero.
// Stack lives in one rpn_ram instance (registered read); operand pops are
// serialised through its single read port.
// Reset (rst, synchronous) empties the stack and clears the status; the stack
// RAM itself is not cleared, since only entries below the pointer are read.
// in_stall is high whenever the sequencer is not in its idle state. out_stall
// holds the result register; a new '=' waits only if it is still occupied.

module rpn_stack_evaluator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         ch,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] value,
  output logic [1:0]         status
);

  rpn_pkg::seq_state_t state, state_next;

  logic [rpn_pkg::PTR_W-1:0] ptr, ptr_next;
  logic [1:0]                err, err_next;
  logic                      out_valid_next;

  // operand holding
  logic [rpn_pkg::DATA_W-1:0] b_val;
  logic                       b_nz;
  logic                       a_nz;
  rpn_pkg::alu_op_t           op_reg;
  rpn_pkg::alu_op_t           op_dec;

  // decode
  logic accept;
  logic is_digit;
  logic is_op;
  logic is_eq;
  logic ptr_nz;
  logic full;
  logic out_load;
  logic [rpn_pkg::PTR_W-1:0] ptr_dec;

  // stack RAM port
  logic                        ram_we;
  logic                        ram_re;
  logic [rpn_pkg::ADDR_W-1:0]  ram_waddr;
  logic [rpn_pkg::ADDR_W-1:0]  ram_raddr;
  logic [rpn_pkg::DATA_W-1:0]  ram_wdata;
  logic [rpn_pkg::DATA_W-1:0]  ram_rdata;

  // shared unit
  rpn_pkg::alu_req_t           alu_req;
  rpn_pkg::alu_rsp_t           alu_rsp;
  logic [rpn_pkg::DATA_W-1:0]  alu_a;
  logic [rpn_pkg::DATA_W-1:0]  alu_result;

  assign accept   = in_valid && !in_stall;
  assign is_digit = (ch >= rpn_pkg::CH_0) && (ch <= rpn_pkg::CH_9);
  assign is_op    = (ch == rpn_pkg::CH_ADD) || (ch == rpn_pkg::CH_SUB) ||
                    (ch == rpn_pkg::CH_MUL) || (ch == rpn_pkg::CH_DIV);
  assign is_eq    = (ch == rpn_pkg::CH_EQ);
  assign ptr_nz   = (ptr != '0);
  assign full     = (ptr == rpn_pkg::PTR_W'(rpn_pkg::STACK_DEPTH));
  assign ptr_dec  = ptr - 1'b1;
  // result register free, or being drained this cycle
  assign out_load = (state == rpn_pkg::S_EQ) && (!out_valid || !out_stall);
  assign alu_a    = a_nz ? ram_rdata : '0;

  always_comb begin
    priority if (ch == rpn_pkg::CH_ADD) op_dec = rpn_pkg::ALU_ADD;
    else if (ch == rpn_pkg::CH_SUB)     op_dec = rpn_pkg::ALU_SUB;
    else if (ch == rpn_pkg::CH_MUL)     op_dec = rpn_pkg::ALU_MUL;
    else                                op_dec = rpn_pkg::ALU_DIV;
  end

  rpn_ram #(
    .WIDTH (rpn_pkg::DATA_W),
    .DEPTH (rpn_pkg::STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rpn_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .a      (alu_a),
    .b      (b_val),
    .rsp    (alu_rsp),
    .result (alu_result)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rpn_pkg::S_IDLE;
      ptr       <= '0;
      err       <= rpn_pkg::ST_OK;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ptr       <= ptr_next;
      err       <= err_next;
      out_valid <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == rpn_pkg::S_IDLE && accept) begin
      b_nz   <= ptr_nz;
      op_reg <= op_dec;
    end
    if (state == rpn_pkg::S_POP_A) begin
      b_val <= b_nz ? ram_rdata : '0;
      a_nz  <= ptr_nz;
    end
    if (out_load) begin
      value  <= b_nz ? ram_rdata : '0;
      status <= err;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rpn_pkg::S_IDLE: begin
        if (accept && is_op) begin
          state_next = rpn_pkg::S_POP_A;
        end else if (accept && is_eq) begin
          state_next = rpn_pkg::S_EQ;
        end
      end
      rpn_pkg::S_POP_A: state_next = rpn_pkg::S_EXEC;
      rpn_pkg::S_EXEC:  state_next = rpn_pkg::S_WAIT;
      rpn_pkg::S_WAIT: begin
        if (alu_rsp.done) begin
          state_next = rpn_pkg::S_IDLE;
        end
      end
      rpn_pkg::S_EQ: begin
        if (out_load) begin
          state_next = rpn_pkg::S_IDLE;
        end
      end
      default: state_next = rpn_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_stall       = 1'b1;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = ptr[rpn_pkg::ADDR_W-1:0];
    ram_raddr      = ptr_dec[rpn_pkg::ADDR_W-1:0];
    ram_wdata      = alu_result;
    alu_req.start  = 1'b0;
    alu_req.op     = op_reg;
    ptr_next       = ptr;
    err_next       = err;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      rpn_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (accept) begin
          priority if (is_digit) begin
            if (full) begin
              if (err == rpn_pkg::ST_OK) err_next = rpn_pkg::ST_OVERFLW;
            end else begin
              ram_we    = 1'b1;
              ram_wdata = rpn_pkg::DATA_W'(ch - rpn_pkg::CH_0);
              ptr_next  = ptr + 1'b1;
            end
          end else if (is_op) begin
            // pop b
            ram_re = ptr_nz;
            if (ptr_nz) ptr_next = ptr_dec;
          end else if (is_eq) begin
            ram_re = ptr_nz;
          end else begin
            // ignored character
          end
        end
      end
      rpn_pkg::S_POP_A: begin
        ram_re = ptr_nz;
        if (ptr_nz) ptr_next = ptr_dec;
      end
      rpn_pkg::S_EXEC: begin
        alu_req.start = 1'b1;
      end
      rpn_pkg::S_WAIT: begin
        // the operand pops just happened, so the push always fits
        if (alu_rsp.done) begin
          ram_we   = 1'b1;
          ptr_next = ptr + 1'b1;
          if (alu_rsp.divzero && err == rpn_pkg::ST_OK) err_next = rpn_pkg::ST_DIVZERO;
        end
      end
      rpn_pkg::S_EQ: begin
        if (out_load) begin
          ptr_next       = '0;
          err_next       = rpn_pkg::ST_OK;
          out_valid_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // pointer never runs past the stack
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    ptr <= rpn_pkg::PTR_W'(rpn_pkg::STACK_DEPTH))
    else $error("stack pointer beyond depth");

  // no write into a full stack
  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !full)
    else $error("stack write while full");

  // shared unit only answers while the sequencer waits for it
  a_alu_done_wait: assert property (@(posedge clk) disable iff (rst)
    alu_rsp.done |-> (state == rpn_pkg::S_WAIT))
    else $error("ALU completion outside wait state");

  // a result appears only out of the equals step, which empties the stack
  a_out_from_eq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == rpn_pkg::S_EQ) && (ptr == '0) &&
                         (err == rpn_pkg::ST_OK))
    else $error("result without equals step");

endmodule

>>> tb/rpn_stack_evaluator_tb.sv
// rpn_stack_evaluator_tb: self-checking bench for the RPN stack evaluator, with its own
// stack predictor in a small scoreboard class. Depends on rpn_pkg and rpn_stack_evaluator.

import rpn_pkg::*;

typedef struct packed {
  logic signed [DATA_W-1:0] value;
  logic [1:0]               status;
} rpn_result_t;

// Tracks the calculator state beat by beat and holds the results still owed on out.
class rpn_scoreboard;
  logic [DATA_W-1:0] words [STACK_DEPTH];
  int unsigned       fill;
  logic [1:0]        sticky;
  rpn_result_t       owed_q [$];
  int unsigned       errors;
  int unsigned       results;

  function new();
    fill    = 0;
    sticky  = ST_OK;
    errors  = 0;
    results = 0;
  endfunction

  function void raise_status(logic [1:0] code);
    if (sticky == ST_OK) sticky = code;
  endfunction

  function void push_word(logic [DATA_W-1:0] w);
    if (fill >= STACK_DEPTH) begin
      raise_status(ST_OVERFLW);
    end else begin
      words[fill] = w;
      fill++;
    end
  endfunction

  function logic [DATA_W-1:0] pop_word();
    if (fill == 0) return '0;
    fill--;
    return words[fill];
  endfunction

  // signed divide, truncating toward zero; most negative / -1 wraps back to itself
  function logic [DATA_W-1:0] quotient(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] mag_a, mag_b, q;
    mag_a = a[DATA_W-1] ? (32'd0 - a) : a;
    mag_b = b[DATA_W-1] ? (32'd0 - b) : b;
    q     = mag_a / mag_b;
    return (a[DATA_W-1] != b[DATA_W-1]) ? (32'd0 - q) : q;
  endfunction

  function void note_char(logic [7:0] c);
    logic [DATA_W-1:0] a, b, r;
    rpn_result_t       res;
    if (c >= CH_0 && c <= CH_9) begin
      push_word(32'(c - CH_0));
      return;
    end
    case (c)
      CH_ADD, CH_SUB, CH_MUL, CH_DIV: begin
        b = pop_word();
        a = pop_word();
        case (c)
          CH_ADD: r = a + b;
          CH_SUB: r = a - b;
          CH_MUL: r = a * b;
          default: begin
            if (b == '0) begin
              raise_status(ST_DIVZERO);
              r = '0;
            end else begin
              r = quotient(a, b);
            end
          end
        endcase
        push_word(r);
      end
      CH_EQ: begin
        res.value  = pop_word();
        res.status = sticky;
        owed_q.push_back(res);
        fill   = 0;
        sticky = ST_OK;
      end
      default: ;
    endcase
  endfunction

  function void check_result(logic signed [DATA_W-1:0] v, logic [1:0] s);
    rpn_result_t want;
    results++;
    if (owed_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, got value %0d status %0d", $time, v, s);
      return;
    end
    want = owed_q.pop_front();
    if (v !== want.value || s !== want.status) begin
      errors++;
      $display("%0t: result mismatch, expected value %0d status %0d, got value %0d status %0d",
               $time, want.value, want.status, v, s);
    end
  endfunction

  function int pending();
    return owed_q.size();
  endfunction
endclass

module rpn_stack_evaluator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // watchdog ceiling with plenty of headroom over the slowest legal run
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int ITEM_TARGET  = 1850;
  localparam int IDLE_PERCENT = 19;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 60;   // long enough to cover any tail work, even of a '/'

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic [7:0]               ch;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DATA_W-1:0] value;
  logic [1:0]               status;

  rpn_scoreboard sb;
  int            items_sent  = 0;   // beats that touch the stack; ignored characters don't count
  int            cycle_count = 0;

  rpn_stack_evaluator i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .ch        (ch),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .status    (status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung block or a lost beat ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** rpn_stack_evaluator: FAILED **");
      $finish;
    end
  end

  // A long window of back-to-back traffic on both sides, no random idling.
  function automatic bit steady_phase();
    return items_sent >= 700 && items_sent < 1000;
  endfunction

  function automatic bit is_active(logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || c == CH_ADD || c == CH_SUB || c == CH_MUL ||
           c == CH_DIV || c == CH_EQ;
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'(CH_0 + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_operator();
    case (alu_op_t'($urandom_range(0, 3)))
      ALU_ADD: return CH_ADD;
      ALU_SUB: return CH_SUB;
      ALU_MUL: return CH_MUL;
      default: return CH_DIV;
    endcase
  endfunction

  function automatic logic [7:0] pick_ignored();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_active(c));
    return c;
  endfunction

  // One input beat. Valid stays high from one beat to the next unless an idle gap is
  // taken; stall is sampled at the falling edge so the accept decision is race-free.
  task automatic send_char(input logic [7:0] c);
    bit taken;
    if (!steady_phase() && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PERCENT);
    end
    in_valid <= 1'b1;
    ch       <= c;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    sb.note_char(c);
    if (is_active(c)) items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Well-formed expression with random content; depth never drops below two before
  // an operator, and the tail folds the stack down to one word before '='.
  task automatic send_expression();
    int steps, depth;
    steps = $urandom_range(1, 16);
    depth = 0;
    for (int k = 0; k < steps; k++) begin
      if (depth < 2 || $urandom_range(0, 2) == 0) begin
        send_char(pick_digit());
        depth++;
      end else begin
        send_char(pick_operator());
        depth--;
      end
      if ($urandom_range(0, 19) == 0) send_char(pick_ignored());
    end
    while (depth > 1) begin
      send_char(pick_operator());
      depth--;
    end
    send_char(CH_EQ);
  endtask

  // Push up to or past the top of the stack so the overflow status can stick, then fold a little.
  task automatic send_overflow();
    int pushes;
    pushes = STACK_DEPTH - 2 + $urandom_range(0, 12);
    repeat (pushes) send_char(pick_digit());
    repeat ($urandom_range(0, 4)) send_char(pick_operator());
    send_char(CH_EQ);
  endtask

  // Wide values: either the most negative word (1 doubled 31 times) or a chain of
  // multiplies by nine that can wrap, then one of a few tails around the extremes.
  task automatic send_extreme();
    if ($urandom_range(0, 1) == 0) begin
      send_char(CH_0 + 8'd1);
      repeat (31) send_text("2*");
    end else begin
      send_char(CH_9);
      repeat ($urandom_range(4, 14)) send_text("9*");
    end
    case ($urandom_range(0, 4))
      0: send_text("01-/=");   // divide by -1
      1: send_text("1-=");     // most negative minus one gives the most positive
      2: send_text("0/=");
      3: send_text("7/=");
      default: send_char(CH_EQ);
    endcase
  endtask

  // Noise: arbitrary bytes, any bit pattern, operators on a thin stack, maybe no '='.
  task automatic send_noise();
    repeat ($urandom_range(1, 10)) begin
      if ($urandom_range(0, 1) == 0) send_char(8'($urandom_range(0, 255)));
      else if ($urandom_range(0, 1) == 0) send_char(pick_operator());
      else send_char(pick_digit());
    end
    if ($urandom_range(0, 1) == 0) send_char(CH_EQ);
  endtask

  // Result monitor: sample at the falling edge, count the beat at the rising edge.
  always begin
    logic                     v_q, s_q;
    logic signed [DATA_W-1:0] val_q;
    logic [1:0]               st_q;
    @(negedge clk);
    v_q   = out_valid;
    s_q   = out_stall;
    val_q = value;
    st_q  = status;
    @(posedge clk);
    if (v_q === 1'b1 && s_q === 1'b0) sb.check_result(val_q, st_q);
  end

  // Receiver: random stall, plus one long hold-off while the sender keeps going, so the
  // result register stays full and the next '=' backs up onto in_stall.
  initial begin
    bit held;
    held      = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && !held && sb.results >= 25) begin
        held = 1'b1;
        out_stall <= 1'b1;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end else begin
        out_stall <= !steady_phase() && ($urandom_range(0, 99) < IDLE_PERCENT);
      end
    end
  end

  initial begin
    int pick;
    sb       = new();
    rst      = 1'b1;
    in_valid = 1'b0;
    ch       = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: '=' on an empty stack, pops from empty, divide by zero, negative
    // truncating divide, a multiply, two errors in a row, NUL and an all-ones byte.
    send_text("=");
    send_text("+=");
    send_text("90/=");
    send_text("07-2/=");
    send_text("10/0/=");
    send_char(8'h00);
    send_char(8'hFF);
    send_text("93*=");

    send_extreme();
    send_overflow();
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) send_expression();
      else if (pick < 82) send_overflow();
      else if (pick < 86) send_extreme();
      else send_noise();
    end
    in_valid <= 1'b0;

    // Drain: every owed result must turn up, then let any late stray beat show.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** rpn_stack_evaluator: PASSED **");
    end else begin
      $display("** rpn_stack_evaluator: FAILED **");
    end
    $finish;
  end
endmodule
